[src/wdtl_pkg.sv]
// ----------------------------------------------------------------------------
// wdtl_pkg: shared types and constants of the window decision tree landmarks
// Job word between the front and back parts, state machine types, codes.
// ----------------------------------------------------------------------------
package wdtl_pkg;

    localparam int CODE_SIZE_DEF  = 4;
    localparam int TREE_DEPTH_DEF = 5;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam logic [6:0] IMAGE_WIDTH_RST  = 7'd32;
    localparam logic [6:0] IMAGE_HEIGHT_RST = 7'd32;

    // A question index is four bits wide, so only the first sixteen window
    // bits can ever be asked.
    localparam int Q_SPAN = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [5:0] TYPE_STEP = 6'd2;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic CMD_NODE  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic               is_node;
        logic [4:0]         node_addr;
        logic               node_stop;
        logic [3:0]         node_question;
        logic [Q_SPAN-1:0]  win;
        logic [7:0]         center_x;
        logic [7:0]         center_y;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_PUSH
    } t_front_state;

    typedef enum logic {
        B_IDLE,
        B_WALK
    } t_back_state;

endpackage

[src/wdtl_front.sv]
// ----------------------------------------------------------------------------
// wdtl_front: pixel position, line store and window update
// Accepts node writes and pixels, builds the window and queues walk jobs.
// ----------------------------------------------------------------------------
module wdtl_front #(
    parameter int CODE_SIZE  = wdtl_pkg::CODE_SIZE_DEF,
    parameter int MAX_WIDTH  = wdtl_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wdtl_pkg::MAX_HEIGHT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [6:0]              i_image_width,
    input  logic [6:0]              i_image_height,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_cmd,
    input  logic [4:0]              i_node_addr,
    input  logic                    i_node_stop,
    input  logic [3:0]              i_node_question,
    input  logic [7:0]              i_pixel,
    input  logic                    i_frame_start,
    input  wdtl_pkg::t_queue_status i_q_status,
    output logic                    o_q_push,
    output wdtl_pkg::t_job          o_q_job
);

    localparam int S     = CODE_SIZE - 1;
    localparam int EXT   = MAX_WIDTH + CODE_SIZE - 1;
    localparam int AW    = $clog2(EXT);
    localparam int CW    = $clog2(MAX_WIDTH + CODE_SIZE);
    localparam int RW    = $clog2(MAX_HEIGHT + CODE_SIZE);
    localparam int SW    = $clog2(S);
    localparam int LW    = (CW > 7) ? CW : 7;
    localparam int LH    = (RW > 7) ? RW : 7;
    localparam int XW    = LW + 1;
    localparam int YW    = LH + 1;
    localparam int WIN   = CODE_SIZE * CODE_SIZE;
    localparam int INNER = (CODE_SIZE - 2) * (CODE_SIZE - 2);

    wdtl_pkg::t_front_state r_state, n_state;

    logic [CW-1:0]   r_col_cnt;
    logic [RW-1:0]   r_row_cnt;
    logic [SW-1:0]   r_slot_cnt;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [SW-1:0]   r_slot;
    logic            r_bit;
    logic [WIN-1:0]  r_win;
    logic [S-1:0]    r_rd_word;
    logic            r_rd_vld;
    logic [S-1:0]    r_line_mem [EXT];
    logic [EXT-1:0]  r_line_vld;
    wdtl_pkg::t_job  r_job;

    logic            accept;
    logic [LW-1:0]   w, ew, col_p, n_col_cnt;
    logic [LH-1:0]   h, eh, row_p, n_row_cnt;
    logic [SW-1:0]   slot_p, n_slot_cnt;
    logic            pix_bit;

    logic [S-1:0]    word, n_word;
    logic [WIN-1:0]  n_win;
    logic [INNER-1:0] inner;
    logic            skip;
    logic [XW-1:0]   cxw;
    logic [YW-1:0]   cyw;
    wdtl_pkg::t_job  calc_job;
    wdtl_pkg::t_job  node_job;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        logic [SW:0] t;
        t = (SW+1)'(s) + (SW+1)'(1);
        if (t >= (SW+1)'(S)) begin
            t = '0;
        end
        return t[SW-1:0];
    endfunction

    assign accept = i_in_valid && !o_in_stall;

    // Position of the arriving pixel and the counters after it.
    always_comb begin
        w = LW'(i_image_width);
        if (w == '0) begin
            w = LW'(1);
        end else if (w > LW'(MAX_WIDTH)) begin
            w = LW'(MAX_WIDTH);
        end
        h = LH'(i_image_height);
        if (h == '0) begin
            h = LH'(1);
        end else if (h > LH'(MAX_HEIGHT)) begin
            h = LH'(MAX_HEIGHT);
        end
        ew = w + LW'(S);
        eh = h + LH'(S);

        if (i_frame_start) begin
            col_p  = '0;
            row_p  = '0;
            slot_p = '0;
        end else begin
            col_p  = LW'(r_col_cnt);
            row_p  = LH'(r_row_cnt);
            slot_p = r_slot_cnt;
        end
        if (col_p >= ew) begin
            col_p  = '0;
            row_p  = row_p + LH'(1);
            slot_p = slot_inc(slot_p);
        end
        if (row_p >= eh) begin
            row_p  = '0;
            slot_p = '0;
        end

        n_col_cnt  = col_p + LW'(1);
        n_row_cnt  = row_p;
        n_slot_cnt = slot_p;
        if (n_col_cnt >= ew) begin
            n_col_cnt  = '0;
            n_row_cnt  = row_p + LH'(1);
            n_slot_cnt = slot_inc(slot_p);
            if (n_row_cnt >= eh) begin
                n_row_cnt  = '0;
                n_slot_cnt = '0;
            end
        end

        pix_bit = (i_pixel != 8'd0) && (col_p < w) && (row_p < h);
    end

    // Window shift, line store update and the skip test.
    always_comb begin
        logic [CODE_SIZE-1:0] rbits;
        logic                 nb;
        logic [SW:0]          ssum;
        word = r_rd_vld ? r_rd_word : '0;
        n_word = word;
        n_word[r_slot] = r_bit;
        n_win = '0;
        for (int dy = 0; dy < CODE_SIZE; dy++) begin
            if (r_col == '0) begin
                rbits = '0;
            end else begin
                rbits = r_win[dy*CODE_SIZE +: CODE_SIZE];
            end
            nb   = 1'b0;
            ssum = '0;
            if (dy == CODE_SIZE - 1) begin
                nb = r_bit;
            end else if ((RW+3)'(r_row) + (RW+3)'(dy) >= (RW+3)'(S)) begin
                ssum = (SW+1)'(r_slot) + (SW+1)'(dy);
                if (ssum >= (SW+1)'(S)) begin
                    ssum = ssum - (SW+1)'(S);
                end
                nb = word[ssum[SW-1:0]];
            end
            n_win[dy*CODE_SIZE +: CODE_SIZE] = {nb, rbits[CODE_SIZE-1:1]};
        end
        for (int dy = 1; dy < CODE_SIZE - 1; dy++) begin
            for (int dx = 1; dx < CODE_SIZE - 1; dx++) begin
                inner[(dy-1)*(CODE_SIZE-2) + (dx-1)] = n_win[dy*CODE_SIZE + dx];
            end
        end
        skip = (inner == '0) || (inner == '1);
        cxw  = XW'(r_col) + XW'(CODE_SIZE / 2) - XW'(S);
        cyw  = YW'(r_row) + YW'(CODE_SIZE / 2) - YW'(S);

        calc_job               = '0;
        calc_job.is_node       = 1'b0;
        calc_job.win           = wdtl_pkg::Q_SPAN'(n_win);
        calc_job.center_x      = cxw[7:0];
        calc_job.center_y      = cyw[7:0];
    end

    always_comb begin
        node_job               = '0;
        node_job.is_node       = 1'b1;
        node_job.node_addr     = i_node_addr;
        node_job.node_stop     = i_node_stop;
        node_job.node_question = i_node_question;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wdtl_pkg::F_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_cmd == wdtl_pkg::CMD_NODE) ? wdtl_pkg::F_PUSH
                                                            : wdtl_pkg::F_CALC;
                end
            end
            wdtl_pkg::F_CALC: begin
                n_state = skip ? wdtl_pkg::F_IDLE : wdtl_pkg::F_PUSH;
            end
            wdtl_pkg::F_PUSH: begin
                if (!i_q_status.full) begin
                    n_state = wdtl_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = wdtl_pkg::F_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_q_push   = 1'b0;
        unique case (r_state)
            wdtl_pkg::F_IDLE: begin
                o_in_stall = 1'b0;
            end
            wdtl_pkg::F_CALC: begin
                o_in_stall = 1'b1;
            end
            wdtl_pkg::F_PUSH: begin
                o_q_push = !i_q_status.full;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign o_q_job = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= wdtl_pkg::F_IDLE;
            r_col_cnt  <= '0;
            r_row_cnt  <= '0;
            r_slot_cnt <= '0;
            r_win      <= '0;
            r_line_vld <= '0;
        end else begin
            r_state <= n_state;
            if (accept && i_cmd == wdtl_pkg::CMD_PIXEL) begin
                r_col_cnt  <= CW'(n_col_cnt);
                r_row_cnt  <= RW'(n_row_cnt);
                r_slot_cnt <= n_slot_cnt;
            end
            if (r_state == wdtl_pkg::F_CALC) begin
                r_win                  <= n_win;
                r_line_vld[r_col[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col     <= CW'(col_p);
            r_row     <= RW'(row_p);
            r_slot    <= slot_p;
            r_bit     <= pix_bit;
            r_rd_word <= r_line_mem[col_p[AW-1:0]];
            r_rd_vld  <= r_line_vld[col_p[AW-1:0]];
        end
        if (r_state == wdtl_pkg::F_CALC) begin
            r_line_mem[r_col[AW-1:0]] <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_cmd == wdtl_pkg::CMD_NODE) begin
            r_job <= node_job;
        end else if (r_state == wdtl_pkg::F_CALC) begin
            r_job <= calc_job;
        end
    end

endmodule

[src/wdtl_queue.sv]
// ----------------------------------------------------------------------------
// wdtl_queue: job queue between the front and back parts
// A short first-in first-out buffer of job words.
// ----------------------------------------------------------------------------
module wdtl_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  wdtl_pkg::t_job          i_job,
    input  logic                    i_pop,
    output wdtl_pkg::t_job          o_head,
    output wdtl_pkg::t_queue_status o_status
);

    localparam int PW = $clog2(wdtl_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(wdtl_pkg::QUEUE_DEPTH + 1);

    wdtl_pkg::t_job r_slots [wdtl_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [NW-1:0]  r_cnt;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW:0] t;
        t = (PW+1)'(p) + (PW+1)'(1);
        if (t >= (PW+1)'(wdtl_pkg::QUEUE_DEPTH)) begin
            t = '0;
        end
        return t[PW-1:0];
    endfunction

    assign o_head         = r_slots[r_rp];
    assign o_status.full  = (r_cnt == NW'(wdtl_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wp] <= i_job;
        end
    end

endmodule

[src/wdtl_back.sv]
// ----------------------------------------------------------------------------
// wdtl_back: decision tree table and tree walk
// Applies node writes and walks the tree for each queued window.
// ----------------------------------------------------------------------------
module wdtl_back #(
    parameter int TREE_DEPTH = wdtl_pkg::TREE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  wdtl_pkg::t_job          i_head,
    input  wdtl_pkg::t_queue_status i_q_status,
    output logic                    o_q_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [7:0]       o_center_x,
    output logic signed [7:0]       o_center_y,
    output logic [5:0]              o_landmark_type,
    output logic                    o_last
);

    localparam int NODES = (1 << TREE_DEPTH) - 1;
    localparam int NAW   = TREE_DEPTH;

    wdtl_pkg::t_back_state r_state, n_state;

    logic [NODES-1:0]         r_stop;
    logic [3:0]               r_quest [NODES];
    logic [5:0]               r_type  [NODES];
    logic [NAW:0]             r_addr;
    logic [wdtl_pkg::Q_SPAN-1:0] r_win;
    logic [7:0]               r_cx;
    logic [7:0]               r_cy;
    logic                     r_pend;
    logic [5:0]               r_pend_type;
    logic                     r_out_valid;
    logic [7:0]               r_out_cx;
    logic [7:0]               r_out_cy;
    logic [5:0]               r_out_type;
    logic                     r_out_last;

    logic                     out_free;
    logic                     in_range;
    logic [NAW-1:0]           idx;
    logic                     cur_ok;
    logic                     ans;
    logic [5:0]               type_out;
    logic [NAW:0]             child;
    logic                     step;
    logic                     emit;
    logic [5:0]               wr_ext;
    logic                     wr_ok;
    logic [NAW-1:0]           wr_idx;
    logic                     node_wr;

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_range = r_addr < (NAW+1)'(NODES);
    assign idx      = r_addr[NAW-1:0];
    assign cur_ok   = in_range && !r_stop[idx];
    assign ans      = r_win[r_quest[idx]];
    assign type_out = r_type[idx] + 6'(ans);
    assign child    = {idx, 1'b0} + (NAW+1)'(1) + (NAW+1)'(ans);

    assign wr_ext   = {1'b0, i_head.node_addr};
    assign wr_ok    = wr_ext < 6'(NODES);
    assign wr_idx   = wr_ext[NAW-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wdtl_pkg::B_IDLE: begin
                if (!i_q_status.empty && !i_head.is_node) begin
                    n_state = wdtl_pkg::B_WALK;
                end
            end
            wdtl_pkg::B_WALK: begin
                if (step && !cur_ok) begin
                    n_state = wdtl_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = wdtl_pkg::B_IDLE;
            end
        endcase
    end

    always_comb begin
        o_q_pop = 1'b0;
        step    = 1'b0;
        emit    = 1'b0;
        node_wr = 1'b0;
        unique case (r_state)
            wdtl_pkg::B_IDLE: begin
                o_q_pop = !i_q_status.empty;
                node_wr = !i_q_status.empty && i_head.is_node && wr_ok;
            end
            wdtl_pkg::B_WALK: begin
                step = !r_pend || out_free;
                emit = r_pend && out_free;
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_center_x      = r_out_cx;
    assign o_center_y      = r_out_cy;
    assign o_landmark_type = r_out_type;
    assign o_last          = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wdtl_pkg::B_IDLE;
            r_stop      <= '1;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NODES; i++) begin
                r_type[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (node_wr) begin
                r_stop[wr_idx] <= i_head.node_stop;
                for (int i = 0; i < NODES; i++) begin
                    if (NAW'(i) > wr_idx) begin
                        if (r_stop[wr_idx] && !i_head.node_stop) begin
                            r_type[i] <= r_type[i] + wdtl_pkg::TYPE_STEP;
                        end else if (!r_stop[wr_idx] && i_head.node_stop) begin
                            r_type[i] <= r_type[i] - wdtl_pkg::TYPE_STEP;
                        end
                    end
                end
            end
            if (step) begin
                r_pend <= cur_ok;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (node_wr) begin
            r_quest[wr_idx] <= i_head.node_question;
        end
        if (r_state == wdtl_pkg::B_IDLE && !i_q_status.empty && !i_head.is_node) begin
            r_addr <= '0;
            r_win  <= i_head.win;
            r_cx   <= i_head.center_x;
            r_cy   <= i_head.center_y;
        end else if (step && cur_ok) begin
            r_addr      <= child;
            r_pend_type <= type_out;
        end
        if (emit) begin
            r_out_cx   <= r_cx;
            r_out_cy   <= r_cy;
            r_out_type <= r_pend_type;
            r_out_last <= !cur_ok;
        end
    end

endmodule

[src/window_decision_tree_landmarks_core.sv]
// ----------------------------------------------------------------------------
// window_decision_tree_landmarks_core: binary window decision tree landmarks
// Walks a decision tree over each square window of a padded binary raster.
// ----------------------------------------------------------------------------
// The input channel carries one word per item: a tree node write (cmd 0) or
// a pixel (cmd 1) of the padded frame in raster order. Node words are applied
// in order with the pixels, so a walk always sees the tree as written before
// its pixel. The output channel carries one word per visited tree node, with
// last set on the final word of a window's path; skipped windows and windows
// whose root is a stop node give no word.
// The front part takes a pixel through a line store read, a window update and
// a queue push (left out when the window is skipped) and a node word through
// the queue push alone; it takes no new item before it is done with the last,
// and the push waits while the queue is full. The back part loads a window,
// steps through its visited nodes, at most TREE_DEPTH, one at a time and ends
// the path with a further step. A four-entry queue lets the two parts run
// apart. Configuration is written on its own channel, always ready; the user
// must write it only while idle, which the block itself does not enforce.
// Reset is synchronous: at the next rising edge it clears the position, the
// window, the line store valid bits and the tree table (all nodes stop).
// While the output is stalled its word holds; a walk with a word ready waits.
// ----------------------------------------------------------------------------
module window_decision_tree_landmarks_core #(
    parameter int CODE_SIZE  = wdtl_pkg::CODE_SIZE_DEF,
    parameter int TREE_DEPTH = wdtl_pkg::TREE_DEPTH_DEF,
    parameter int MAX_WIDTH  = wdtl_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wdtl_pkg::MAX_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [6:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_cmd,
    input  logic [4:0]        i_node_addr,
    input  logic              i_node_stop,
    input  logic [3:0]        i_node_question,
    input  logic [7:0]        i_pixel,
    input  logic              i_frame_start,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic signed [7:0] o_center_x,
    output logic signed [7:0] o_center_y,
    output logic [5:0]        o_landmark_type,
    output logic              o_last
);

    logic [6:0]              r_image_width;
    logic [6:0]              r_image_height;
    logic                    q_push;
    logic                    q_pop;
    wdtl_pkg::t_job          q_in_job;
    wdtl_pkg::t_job          q_head;
    wdtl_pkg::t_queue_status q_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= wdtl_pkg::IMAGE_WIDTH_RST;
            r_image_height <= wdtl_pkg::IMAGE_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                wdtl_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                wdtl_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: begin
                    r_image_width <= r_image_width;
                end
            endcase
        end
    end

    wdtl_front #(
        .CODE_SIZE  (CODE_SIZE),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_image_width   (r_image_width),
        .i_image_height  (r_image_height),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_node_addr     (i_node_addr),
        .i_node_stop     (i_node_stop),
        .i_node_question (i_node_question),
        .i_pixel         (i_pixel),
        .i_frame_start   (i_frame_start),
        .i_q_status      (q_status),
        .o_q_push        (q_push),
        .o_q_job         (q_in_job)
    );

    wdtl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_job    (q_in_job),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    wdtl_back #(
        .TREE_DEPTH (TREE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (q_head),
        .i_q_status      (q_status),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_center_x      (o_center_x),
        .o_center_y      (o_center_y),
        .o_landmark_type (o_landmark_type),
        .o_last          (o_last)
    );

endmodule
